// ===== sv/x86d_pkg.sv =====
`default_nettype none
package x86d_pkg;

  localparam logic [3:0] K_NONE   = 4'd0;
  localparam logic [3:0] K_REG    = 4'd1;
  localparam logic [3:0] K_MEM    = 4'd2;
  localparam logic [3:0] K_DIRECT = 4'd3;
  localparam logic [3:0] K_IMM    = 4'd4;
  localparam logic [3:0] K_SEG    = 4'd5;
  localparam logic [3:0] K_DX     = 4'd6;
  localparam logic [3:0] K_PORT   = 4'd7;
  localparam logic [3:0] K_JUMP   = 4'd8;

  localparam logic [5:0] M_LDS    = 6'd0;
  localparam logic [5:0] M_LES    = 6'd1;
  localparam logic [5:0] M_AAA    = 6'd2;
  localparam logic [5:0] M_DAA    = 6'd3;
  localparam logic [5:0] M_AAS    = 6'd4;
  localparam logic [5:0] M_DAS    = 6'd5;
  localparam logic [5:0] M_LAHF   = 6'd6;
  localparam logic [5:0] M_SAHF   = 6'd7;
  localparam logic [5:0] M_PUSHF  = 6'd8;
  localparam logic [5:0] M_POPF   = 6'd9;
  localparam logic [5:0] M_MOV    = 6'd10;
  localparam logic [5:0] M_ADD    = 6'd11;
  localparam logic [5:0] M_ADC    = 6'd12;
  localparam logic [5:0] M_CMP    = 6'd13;
  localparam logic [5:0] M_SUB    = 6'd14;
  localparam logic [5:0] M_SBB    = 6'd15;
  localparam logic [5:0] M_PUSH   = 6'd16;
  localparam logic [5:0] M_INC    = 6'd17;
  localparam logic [5:0] M_DEC    = 6'd18;
  localparam logic [5:0] M_NEG    = 6'd19;
  localparam logic [5:0] M_MUL    = 6'd20;
  localparam logic [5:0] M_IMUL   = 6'd21;
  localparam logic [5:0] M_JO     = 6'd22;
  localparam logic [5:0] M_LOOPNZ = 6'd38;
  localparam logic [5:0] M_POP    = 6'd42;
  localparam logic [5:0] M_XCHG   = 6'd43;
  localparam logic [5:0] M_IN     = 6'd44;
  localparam logic [5:0] M_OUT    = 6'd45;
  localparam logic [5:0] M_XLAT   = 6'd46;
  localparam logic [5:0] M_LEA    = 6'd47;

  localparam logic [7:0] ALU_VALID = 8'hAD;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  typedef struct packed {
    logic       bad;
    logic       xbad;
    logic       has_modrm;
    logic [5:0] mn;
    logic       w;
    logic [3:0] dk;
    logic [2:0] di;
    logic [3:0] sk;
    logic [2:0] si;
    logic [1:0] ndisp;
    logic [1:0] nimm;
    logic       imm_sext;
    logic       jump;
  } dec_t;

  // one finished instruction as handed from front to back
  typedef struct packed {
    logic        bad;
    dec_t        d;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [2:0]  len;
  } rec_t;

  function automatic logic [5:0] alu_mn(input logic [2:0] op);
    logic [5:0] r;
    case (op)
      3'd0: r = M_ADD;
      3'd2: r = M_ADC;
      3'd3: r = M_SBB;
      3'd5: r = M_SUB;
      3'd7: r = M_CMP;
      default: r = 6'd0;
    endcase
    return r;
  endfunction

  function automatic dec_t decode(input logic [7:0] fb, input logic [7:0] m);
    dec_t d;
    logic w, dbit, aluok;
    logic [2:0] reg_f, rm;
    logic [1:0] md;
    logic [3:0] rk;
    logic [2:0] ri;
    logic [1:0] nd;
    w = fb[0];
    dbit = fb[1];
    reg_f = m[5:3];
    md = m[7:6];
    rm = m[2:0];
    aluok = ALU_VALID[fb[5:3]];
    if (md == 2'd3) begin
      rk = K_REG; ri = rm; nd = 2'd0;
    end else if (md == 2'd0 && rm == 3'd6) begin
      rk = K_DIRECT; ri = 3'd0; nd = 2'd2;
    end else begin
      rk = K_MEM; ri = rm;
      nd = (md == 2'd0) ? 2'd0 : ((md == 2'd1) ? 2'd1 : 2'd2);
    end
    d = '0;
    if (fb == 8'hc5 || fb == 8'hc4 || fb == 8'h8d || (fb >= 8'h86 && fb <= 8'h8b) ||
        (fb < 8'h40 && fb[2:0] < 3'd4 && aluok)) begin
      d.has_modrm = 1'b1; d.ndisp = nd; d.w = w;
      if (fb == 8'hc5) begin
        d.mn = M_LDS; d.w = 1'b1; dbit = 1'b1;
      end else if (fb == 8'hc4) begin
        d.mn = M_LES; d.w = 1'b1; dbit = 1'b1;
      end else if (fb == 8'h8d) begin
        d.mn = M_LEA; d.w = 1'b1; dbit = 1'b1;
      end else if (fb >= 8'h86 && fb <= 8'h8b) begin
        if (fb <= 8'h87) begin
          d.mn = M_XCHG; dbit = 1'b1;
        end else d.mn = M_MOV;
      end else d.mn = alu_mn(fb[5:3]);
      if (dbit) begin
        d.dk = K_REG; d.di = reg_f; d.sk = rk; d.si = ri;
      end else begin
        d.dk = rk; d.di = ri; d.sk = K_REG; d.si = reg_f;
      end
    end else if (fb < 8'h40 && (fb[2:0] == 3'd4 || fb[2:0] == 3'd5) && aluok) begin
      d.mn = alu_mn(fb[5:3]); d.w = w; d.dk = K_REG; d.sk = K_IMM;
      d.nimm = w ? 2'd2 : 2'd1;
    end else if (fb == 8'h37) d.mn = M_AAA;
    else if (fb == 8'h27) d.mn = M_DAA;
    else if (fb == 8'h3f) d.mn = M_AAS;
    else if (fb == 8'h2f) d.mn = M_DAS;
    else if (fb == 8'h9f) d.mn = M_LAHF;
    else if (fb == 8'h9e) d.mn = M_SAHF;
    else if (fb == 8'h9c) d.mn = M_PUSHF;
    else if (fb == 8'h9d) d.mn = M_POPF;
    else if (fb == 8'hd7) d.mn = M_XLAT;
    else if (fb >= 8'ha0 && fb <= 8'ha3) begin
      d.mn = M_MOV; d.w = w; d.ndisp = 2'd2;
      if (fb <= 8'ha1) begin
        d.dk = K_REG; d.sk = K_DIRECT;
      end else begin
        d.dk = K_DIRECT; d.sk = K_REG;
      end
    end else if (fb == 8'hfe || fb == 8'hff || fb == 8'hf6 || fb == 8'hf7 ||
                 fb == 8'h8f) begin
      d.has_modrm = 1'b1; d.ndisp = nd; d.w = w; d.dk = rk; d.di = ri;
      if (fb == 8'h8f) begin
        d.mn = M_POP; d.xbad = (reg_f != 3'd0);
      end else if (fb >= 8'hfe) begin
        if (fb == 8'hff && reg_f == 3'd6) d.mn = M_PUSH;
        else if (reg_f == 3'd0) d.mn = M_INC;
        else if (reg_f == 3'd1) d.mn = M_DEC;
        else d.xbad = 1'b1;
      end else begin
        if (reg_f == 3'd3) d.mn = M_NEG;
        else if (reg_f == 3'd4) d.mn = M_MUL;
        else if (reg_f == 3'd5) d.mn = M_IMUL;
        else d.xbad = 1'b1;
      end
    end else if (fb >= 8'h40 && fb <= 8'h5f) begin
      case (fb[4:3])
        2'd0: d.mn = M_INC;
        2'd1: d.mn = M_DEC;
        2'd2: d.mn = M_PUSH;
        default: d.mn = M_POP;
      endcase
      d.w = 1'b1; d.dk = K_REG; d.di = fb[2:0];
    end else if (fb >= 8'h80 && fb <= 8'h83) begin
      d.has_modrm = 1'b1; d.ndisp = nd; d.w = w; d.dk = rk; d.di = ri; d.sk = K_IMM;
      d.mn = alu_mn(reg_f); d.xbad = !ALU_VALID[reg_f];
      d.nimm = (w && !dbit) ? 2'd2 : 2'd1;
      d.imm_sext = w && dbit;
    end else if (fb == 8'hc6 || fb == 8'hc7) begin
      d.has_modrm = 1'b1; d.ndisp = nd; d.w = w; d.dk = rk; d.di = ri; d.sk = K_IMM;
      d.mn = M_MOV; d.nimm = w ? 2'd2 : 2'd1;
    end else if (fb >= 8'hb0 && fb <= 8'hbf) begin
      d.mn = M_MOV; d.w = fb[3]; d.dk = K_REG; d.di = fb[2:0]; d.sk = K_IMM;
      d.nimm = fb[3] ? 2'd2 : 2'd1;
    end else if (fb >= 8'h70 && fb <= 8'h7f) begin
      d.mn = M_JO + {2'b00, fb[3:0]}; d.dk = K_JUMP; d.ndisp = 2'd1; d.jump = 1'b1;
    end else if (fb >= 8'he0 && fb <= 8'he3) begin
      d.mn = M_LOOPNZ + {4'b0000, fb[1:0]}; d.dk = K_JUMP; d.ndisp = 2'd1;
      d.jump = 1'b1;
    end else if (fb < 8'h20 && fb[2:1] == 2'b11) begin
      d.mn = fb[0] ? M_POP : M_PUSH; d.w = 1'b1; d.dk = K_SEG; d.di = {1'b0, fb[4:3]};
    end else if (fb >= 8'h90 && fb <= 8'h97) begin
      d.mn = M_XCHG; d.w = 1'b1; d.dk = K_REG; d.sk = K_REG; d.si = fb[2:0];
    end else if (fb == 8'he4 || fb == 8'he5 || fb == 8'hec || fb == 8'hed) begin
      d.mn = M_IN; d.w = w; d.dk = K_REG;
      if (fb <= 8'he5) begin
        d.sk = K_PORT; d.nimm = 2'd1;
      end else d.sk = K_DX;
    end else if (fb == 8'he6 || fb == 8'he7 || fb == 8'hee || fb == 8'hef) begin
      d.mn = M_OUT; d.w = w; d.sk = K_REG;
      if (fb <= 8'he7) begin
        d.dk = K_PORT; d.nimm = 2'd1;
      end else d.dk = K_DX;
    end else begin
      d.bad = 1'b1;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== sv/x86d_front.sv =====
`default_nettype none
module x86d_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [7:0]       byte_value_i,
  input  wire logic             byte_valid_i,
  output logic                  byte_ready_o,
  output x86d_pkg::rec_t        rec_o,
  output logic                  rec_valid_o,
  input  wire logic             rec_ready_i
);

  typedef enum logic [1:0] {PH_OPCODE, PH_MODRM, PH_TAIL} phase_e;

  phase_e         phase_q;
  logic [7:0]     fb_q, modrm_q;
  logic [15:0]    disp_q, imm_q;
  logic [2:0]     left_q, cnt_q;
  x86d_pkg::dec_t dec;
  logic [7:0]     fb_sel, m_sel;
  logic           take;
  logic [2:0]     total, pos, nd3;

  // a byte can always be taken when the queue has room for the record it may make
  assign byte_ready_o = rec_ready_i;
  assign take = byte_valid_i && rec_ready_i;

  always_comb begin
    fb_sel = fb_q;
    m_sel = modrm_q;
    if (phase_q == PH_OPCODE) begin
      fb_sel = byte_value_i; m_sel = 8'h00;
    end else if (phase_q == PH_MODRM) begin
      m_sel = byte_value_i;
    end
    dec = x86d_pkg::decode(fb_sel, m_sel);
    nd3 = {1'b0, dec.ndisp};
    total = nd3 + {1'b0, dec.nimm};
    pos = total - left_q;
  end

  always_comb begin
    rec_valid_o = 1'b0;
    rec_o = '0;
    rec_o.d = dec;
    rec_o.disp = disp_q;
    rec_o.imm = imm_q;
    rec_o.len = cnt_q;
    if (take) begin
      unique case (phase_q)
        PH_OPCODE: begin
          rec_o.disp = '0; rec_o.imm = '0; rec_o.len = 3'd1;
          if (dec.bad) begin
            rec_valid_o = 1'b1; rec_o.bad = 1'b1;
          end else if (!dec.has_modrm && total == 3'd0) rec_valid_o = 1'b1;
        end
        PH_MODRM: begin
          rec_o.len = 3'd2;
          if (dec.xbad) begin
            rec_valid_o = 1'b1; rec_o.bad = 1'b1;
          end else if (total == 3'd0) rec_valid_o = 1'b1;
        end
        PH_TAIL: begin
          if (left_q == 3'd0 || left_q > total) rec_valid_o = 1'b1;
          else begin
            if (pos < nd3) begin
              if (pos[0]) rec_o.disp[15:8] = disp_q[15:8] | byte_value_i;
              else rec_o.disp[7:0] = disp_q[7:0] | byte_value_i;
            end else begin
              if (pos[0] ^ nd3[0]) rec_o.imm[15:8] = imm_q[15:8] | byte_value_i;
              else rec_o.imm[7:0] = imm_q[7:0] | byte_value_i;
            end
            rec_o.len = cnt_q + 3'd1;
            rec_valid_o = (left_q == 3'd1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      fb_q <= '0; modrm_q <= '0; disp_q <= '0; imm_q <= '0;
      left_q <= '0; cnt_q <= '0;
    end else if (take) begin
      unique case (phase_q)
        PH_OPCODE: begin
          fb_q <= byte_value_i; modrm_q <= '0; disp_q <= '0; imm_q <= '0;
          cnt_q <= 3'd1; left_q <= total;
          if (dec.bad) begin
            phase_q <= PH_OPCODE; left_q <= '0;
          end else if (dec.has_modrm) begin
            phase_q <= PH_MODRM; left_q <= left_q;
          end else if (total == 3'd0) phase_q <= PH_OPCODE;
          else phase_q <= PH_TAIL;
        end
        PH_MODRM: begin
          modrm_q <= byte_value_i; cnt_q <= 3'd2;
          if (dec.xbad) phase_q <= PH_OPCODE;
          else begin
            left_q <= total;
            phase_q <= (total == 3'd0) ? PH_OPCODE : PH_TAIL;
          end
        end
        PH_TAIL: begin
          if (left_q == 3'd0 || left_q > total) begin
            phase_q <= PH_OPCODE; left_q <= '0;
          end else begin
            disp_q <= rec_o.disp; imm_q <= rec_o.imm; cnt_q <= rec_o.len;
            left_q <= left_q - 3'd1;
            if (left_q == 3'd1) phase_q <= PH_OPCODE;
          end
        end
        default: phase_q <= PH_OPCODE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/x86d_queue.sv =====
`default_nettype none
module x86d_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  x86d_pkg::rec_t      wr_data_i,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  output x86d_pkg::rec_t      rd_data_o,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i
);

  x86d_pkg::rec_t            mem_q [x86d_pkg::QDEPTH];
  logic [x86d_pkg::QAW-1:0]  wp_q, rp_q;
  logic [x86d_pkg::QAW:0]    cnt_q;
  logic                      wr, rd;

  assign wr_ready_o = (cnt_q != (x86d_pkg::QAW+1)'(x86d_pkg::QDEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + {{x86d_pkg::QAW{1'b0}}, wr} - {{x86d_pkg::QAW{1'b0}}, rd};
    end
  end

endmodule
`default_nettype wire

// ===== sv/x86d_back.sv =====
`default_nettype none
module x86d_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  x86d_pkg::rec_t      rec_i,
  input  wire logic           rec_valid_i,
  output logic                rec_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [5:0]          mnemonic_o,
  output logic                word_op_o,
  output logic [3:0]          dest_kind_o,
  output logic [2:0]          dest_index_o,
  output logic [3:0]          src_kind_o,
  output logic [2:0]          src_index_o,
  output logic signed [15:0]  displacement_o,
  output logic [15:0]         immediate_o,
  output logic signed [8:0]   jump_offset_o,
  output logic [2:0]          length_o,
  output logic                bad_opcode_o
);

  logic        valid_q;
  logic [15:0] disp_d, imm_d;
  logic [8:0]  jo_d;

  assign rec_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;

  always_comb begin
    disp_d = rec_i.disp;
    imm_d = rec_i.imm;
    jo_d = '0;
    if (rec_i.d.jump) begin
      jo_d = {rec_i.disp[7], rec_i.disp[7:0]} + 9'd2;
      disp_d = '0;
    end else if (rec_i.d.ndisp == 2'd1) disp_d = {{8{rec_i.disp[7]}}, rec_i.disp[7:0]};
    if (rec_i.d.imm_sext && rec_i.d.nimm == 2'd1) imm_d = {{8{rec_i.imm[7]}}, rec_i.imm[7:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (rec_ready_o) valid_q <= rec_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (rec_ready_o && rec_valid_i) begin
      length_o <= rec_i.len;
      bad_opcode_o <= rec_i.bad;
      if (rec_i.bad) begin
        mnemonic_o <= '0; word_op_o <= 1'b0; dest_kind_o <= '0; dest_index_o <= '0;
        src_kind_o <= '0; src_index_o <= '0; displacement_o <= '0; immediate_o <= '0;
        jump_offset_o <= '0;
      end else begin
        mnemonic_o <= rec_i.d.mn; word_op_o <= rec_i.d.w;
        dest_kind_o <= rec_i.d.dk; dest_index_o <= rec_i.d.di;
        src_kind_o <= rec_i.d.sk; src_index_o <= rec_i.d.si;
        displacement_o <= disp_d; immediate_o <= imm_d; jump_offset_o <= jo_d;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/x86_16bit_instruction_decoder.sv =====
`default_nettype none
// 8086 decoder taking one instruction byte per cycle. The front classifies each byte and
// hands a finished record (1 to 6 bytes of instruction) to a four-entry queue as the last
// byte is taken; the back then loads it from the queue into the output register, so a record
// passes the queue and the output register before it is offered. Bytes flow one per
// cycle as long as the queue has room; once it is full the byte side stalls until the
// output register drains.
module x86_16bit_instruction_decoder (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [7:0]     byte_value_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [5:0]          mnemonic_o,
  output logic                word_op_o,
  output logic [3:0]          dest_kind_o,
  output logic [2:0]          dest_index_o,
  output logic [3:0]          src_kind_o,
  output logic [2:0]          src_index_o,
  output logic signed [15:0]  displacement_o,
  output logic [15:0]         immediate_o,
  output logic signed [8:0]   jump_offset_o,
  output logic [2:0]          length_o,
  output logic                bad_opcode_o
);

  x86d_pkg::rec_t f_rec, q_rec;
  logic f_valid, f_ready, q_valid, q_ready;

  x86d_front u_front (
    .clk_i, .rst_ni, .byte_value_i, .byte_valid_i(in_valid_i), .byte_ready_o(in_ready_o),
    .rec_o(f_rec), .rec_valid_o(f_valid), .rec_ready_i(f_ready)
  );

  x86d_queue u_queue (
    .clk_i, .rst_ni, .wr_data_i(f_rec), .wr_valid_i(f_valid), .wr_ready_o(f_ready),
    .rd_data_o(q_rec), .rd_valid_o(q_valid), .rd_ready_i(q_ready)
  );

  x86d_back u_back (
    .clk_i, .rst_ni, .rec_i(q_rec), .rec_valid_i(q_valid), .rec_ready_o(q_ready),
    .out_valid_o, .out_ready_i, .mnemonic_o, .word_op_o, .dest_kind_o, .dest_index_o,
    .src_kind_o, .src_index_o, .displacement_o, .immediate_o, .jump_offset_o,
    .length_o, .bad_opcode_o
  );

endmodule
`default_nettype wire

// ===== sv/x86d_checker.sv =====
`default_nettype none
module x86d_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [2:0] length_o,
  input wire logic       bad_opcode_o,
  input wire logic [5:0] mnemonic_o
);

  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (length_o != 3'd0 && length_o != 3'd7))
    else $error("length out of range");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_opcode_o) |-> (mnemonic_o == 6'd0 && length_o <= 3'd2))
    else $error("bad record not cleared");
  a_mn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mnemonic_o <= 6'd47))
    else $error("mnemonic out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(length_o)))
    else $error("stalled output changed");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> !$isunknown(in_ready_o))
    else $error("input ready unknown");

endmodule

bind x86_16bit_instruction_decoder x86d_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .length_o, .bad_opcode_o, .mnemonic_o
);
`default_nettype wire
